// File: src/pva_pkg.sv
// Shared types and constants for the polyphonic voice allocator.
// Command and result words, controller command struct, operation codes.
// No dependencies.
package pva_pkg;

  // sizing
  localparam int Channels = 16;
  localparam int Voices   = 4;
  localparam int ChanW    = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int VoiceW   = (Voices > 1) ? $clog2(Voices) : 1;
  localparam int TickW    = 31;
  localparam int PeakW    = 3;

  // operation codes, code 3 is ignored like other events
  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpNote  = 2'd1,
    OpOther = 2'd2
  } op_e;

  // input word
  typedef struct packed {
    logic [1:0]       operation;
    logic [3:0]       channel;
    logic [TickW-1:0] start_tick;
    logic [TickW-1:0] end_tick;
  } cmd_t;

  // result word
  typedef struct packed {
    logic             assigned;
    logic [1:0]       voice_slot;
    logic             stolen;
    logic [PeakW-1:0] peak_voices;
  } res_t;

  // one voice slot as stored in the tick memory
  typedef struct packed {
    logic [TickW-1:0] start_tick;
    logic [TickW-1:0] end_tick;
  } slot_ent_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

// File: src/pva_ctrl.sv
// Controller for the voice allocator: idle / execute sequencing.
// Issues load and execute commands to the datapath.
// Depends on pva_pkg.
module pva_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output pva_pkg::ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start) state_d = StExec;
      end
      StExec: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // commands to the datapath
  assign busy        = (state_q == StExec);
  assign ctrl_o.load = start && (state_q == StIdle);
  assign ctrl_o.exec = (state_q == StExec);

endmodule

// File: src/pva_dp.sv
// Datapath for the voice allocator: slot tick memory, busy flags, peak counts,
// expiry / steal / lowest-free selection and the result register.
// Depends on pva_pkg.
module pva_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pva_pkg::ctrl_t ctrl_i,
  input  pva_pkg::cmd_t  cmd_i,
  output pva_pkg::res_t  res_o,
  output logic           done_o
);

  pva_pkg::cmd_t                           cmd_q;
  pva_pkg::slot_ent_t [pva_pkg::Voices-1:0] row_q;
  pva_pkg::slot_ent_t [pva_pkg::Voices-1:0] row_d;
  pva_pkg::slot_ent_t [pva_pkg::Voices-1:0] mem_q [pva_pkg::Channels];
  logic [pva_pkg::Voices-1:0]              busy_q [pva_pkg::Channels];
  logic [pva_pkg::PeakW-1:0]               peak_q [pva_pkg::Channels];
  pva_pkg::res_t                           res_q, res_d;
  logic                                    done_q;

  logic [pva_pkg::ChanW-1:0]  chan_idx;
  logic                       is_clear;
  logic                       is_note;
  logic [pva_pkg::Voices-1:0] live;
  logic [pva_pkg::Voices-1:0] oldest;
  logic [pva_pkg::Voices-1:0] occ;
  logic [pva_pkg::Voices-1:0] new_occ;
  logic                       full;
  logic [pva_pkg::VoiceW-1:0] pick_idx;
  logic [pva_pkg::VoiceW-1:0] highest;
  logic [pva_pkg::PeakW-1:0]  peak_cand;
  logic [pva_pkg::PeakW-1:0]  peak_d;

  // latch the accepted word and read the channel's slot row
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      row_q <= mem_q[cmd_i.channel[pva_pkg::ChanW-1:0]];
    end
  end

  assign chan_idx = cmd_q.channel[pva_pkg::ChanW-1:0];

  // operation decode
  always_comb begin
    is_clear = 1'b0;
    is_note  = 1'b0;
    unique case (cmd_q.operation)
      pva_pkg::OpClear: is_clear = 1'b1;
      pva_pkg::OpNote: begin
        is_note = (5'(cmd_q.channel) < 5'(pva_pkg::Channels));
      end
      default: begin
        is_clear = 1'b0;
        is_note  = 1'b0;
      end
    endcase
  end

  // expiry and oldest-start search, all pairwise compares in parallel
  always_comb begin
    for (int v = 0; v < pva_pkg::Voices; v++) begin
      live[v]   = busy_q[chan_idx][v] && (row_q[v].end_tick > cmd_q.start_tick);
      oldest[v] = 1'b1;
      for (int j = 0; j < pva_pkg::Voices; j++) begin
        if (j < v) begin
          if (!(row_q[v].start_tick < row_q[j].start_tick)) oldest[v] = 1'b0;
        end else if (j > v) begin
          if (!(row_q[v].start_tick <= row_q[j].start_tick)) oldest[v] = 1'b0;
        end
      end
    end
  end

  assign full = &live;
  assign occ  = full ? (live & ~oldest) : live;

  // lowest free slot, highest occupied slot, new peak
  always_comb begin
    pick_idx = '0;
    for (int v = pva_pkg::Voices - 1; v >= 0; v--) begin
      if (!occ[v]) pick_idx = pva_pkg::VoiceW'(v);
    end
    new_occ           = occ;
    new_occ[pick_idx] = 1'b1;
    highest           = '0;
    for (int v = 0; v < pva_pkg::Voices; v++) begin
      if (new_occ[v]) highest = pva_pkg::VoiceW'(v);
    end
    peak_cand = pva_pkg::PeakW'(highest) + pva_pkg::PeakW'(1);
    peak_d    = (peak_cand > peak_q[chan_idx]) ? peak_cand : peak_q[chan_idx];
  end

  // updated slot row
  always_comb begin
    row_d                     = row_q;
    row_d[pick_idx].start_tick = cmd_q.start_tick;
    row_d[pick_idx].end_tick   = cmd_q.end_tick;
  end

  // tick memory write-back
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && is_note) begin
      mem_q[chan_idx] <= row_d;
    end
  end

  // busy flags and peak counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '{default: '0};
      peak_q <= '{default: '0};
    end else if (ctrl_i.exec) begin
      if (is_clear) begin
        busy_q <= '{default: '0};
        peak_q <= '{default: '0};
      end else if (is_note) begin
        busy_q[chan_idx] <= new_occ;
        peak_q[chan_idx] <= peak_d;
      end
    end
  end

  // result word
  always_comb begin
    res_d             = '0;
    res_d.assigned    = is_note;
    res_d.voice_slot  = is_note ? 2'(pick_idx) : 2'd0;
    res_d.stolen      = is_note && full;
    res_d.peak_voices = is_note ? peak_d : '0;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.exec;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// File: src/polyphonic_voice_allocator.sv
// Polyphonic voice allocator, top level: controller plus datapath.
// A word accepted while idle is latched and then executed; the result and done_o are registered.
// A new word is taken only in the idle state, after the slot row read and its write-back.
// Reset clears busy flags, peak counts and control; tick memory is not cleared.
// The result strobe done_o lasts one cycle and cannot be stalled.
// Depends on pva_pkg, pva_ctrl, pva_dp.
module polyphonic_voice_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pva_pkg::cmd_t cmd_i,
  output pva_pkg::res_t res_o,
  output logic          done_o
);

  pva_pkg::ctrl_t ctrl;

  pva_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  pva_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cmd_i  (cmd_i),
    .res_o  (res_o),
    .done_o (done_o)
  );

  // every accepted word gives one result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("missing result after accepted word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("execute lasted more than one cycle");

  // unassigned results carry zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.assigned) |->
      (res_o.voice_slot == 2'd0) && !res_o.stolen && (res_o.peak_voices == 3'd0))
    else $error("unassigned result with nonzero fields");

  // the peak covers the slot just given
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.assigned) |->
      (res_o.peak_voices > {1'b0, res_o.voice_slot}) &&
      (res_o.peak_voices <= 3'(pva_pkg::Voices)))
    else $error("peak count inconsistent with slot");

endmodule

// File: test/tb_polyphonic_voice_allocator.sv
// Self-checking testbench for polyphonic_voice_allocator: directed and random note traffic.
// Results are predicted per channel in the bench and compared with every done_o strobe.
// Depends on pva_pkg and polyphonic_voice_allocator.
module tb_polyphonic_voice_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  // op code 3 has no enum member, the block ignores it like OpOther
  localparam logic [1:0]                OpSpare  = 2'd3;
  localparam logic [pva_pkg::TickW-1:0] TickMax  = '1;
  localparam int                        ShowMax  = 10;
  localparam int                        DrainMax = 2000;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  pva_pkg::cmd_t cmd_i;
  pva_pkg::res_t res_o;
  logic          done_o;

  polyphonic_voice_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .res_o  (res_o),
    .done_o (done_o)
  );

  // predicted voice state per channel
  logic                      slot_live [pva_pkg::Channels][pva_pkg::Voices];
  logic [pva_pkg::TickW-1:0] slot_on   [pva_pkg::Channels][pva_pkg::Voices];
  logic [pva_pkg::TickW-1:0] slot_off  [pva_pkg::Channels][pva_pkg::Voices];
  logic [pva_pkg::PeakW-1:0] chan_peak [pva_pkg::Channels];

  pva_pkg::res_t             pending_results[$];
  pva_pkg::res_t             want;
  int                        idle_pct;
  logic [pva_pkg::TickW-1:0] tick_now;
  int                        words_sent;
  int                        notes_placed;
  int                        steals_seen;
  int                        clears_sent;
  int                        results_seen;
  int                        bad_results;

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // run limit
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  // voice allocation for one accepted word, updates the predicted state
  function automatic pva_pkg::res_t allocate_voice(input pva_pkg::cmd_t w);
    pva_pkg::res_t r;
    int            live;
    int            pick;
    int            top;
    logic [3:0]    ch;
    r  = '0;
    ch = w.channel;
    if (w.operation == pva_pkg::OpClear) begin
      for (int c = 0; c < pva_pkg::Channels; c++) begin
        chan_peak[c] = '0;
        for (int v = 0; v < pva_pkg::Voices; v++) slot_live[c][v] = 1'b0;
      end
      return r;
    end
    if (w.operation != pva_pkg::OpNote || ch >= pva_pkg::Channels) return r;
    // release voices that ended by this start
    live = 0;
    for (int v = 0; v < pva_pkg::Voices; v++) begin
      if (slot_live[ch][v]) begin
        if (slot_off[ch][v] <= w.start_tick) slot_live[ch][v] = 1'b0;
        else live++;
      end
    end
    // full channel: take over the oldest note, lowest slot on a tie
    if (live == pva_pkg::Voices) begin
      pick = 0;
      for (int v = 1; v < pva_pkg::Voices; v++) begin
        if (slot_on[ch][v] < slot_on[ch][pick]) pick = v;
      end
      slot_live[ch][pick] = 1'b0;
      r.stolen = 1'b1;
    end
    // lowest free slot
    pick = 0;
    for (int v = pva_pkg::Voices - 1; v >= 0; v--) begin
      if (!slot_live[ch][v]) pick = v;
    end
    slot_live[ch][pick] = 1'b1;
    slot_on[ch][pick]   = w.start_tick;
    slot_off[ch][pick]  = w.end_tick;
    // peak follows the highest occupied slot
    top = 0;
    for (int v = 0; v < pva_pkg::Voices; v++) begin
      if (slot_live[ch][v]) top = v;
    end
    if (chan_peak[ch] < top + 1) chan_peak[ch] = pva_pkg::PeakW'(top + 1);
    r.assigned    = 1'b1;
    r.voice_slot  = 2'(pick);
    r.peak_voices = chan_peak[ch];
    return r;
  endfunction

  function automatic pva_pkg::cmd_t make_word(input logic [1:0] op, input int ch,
                                              input logic [pva_pkg::TickW-1:0] s,
                                              input logic [pva_pkg::TickW-1:0] e);
    pva_pkg::cmd_t w;
    w.operation  = op;
    w.channel    = 4'(ch);
    w.start_tick = s;
    w.end_tick   = e;
    return w;
  endfunction

  // random word: mostly time-ordered notes on a few channels, some noise
  function automatic pva_pkg::cmd_t random_word();
    pva_pkg::cmd_t w;
    int unsigned   roll;
    roll = $urandom_range(99);
    w.channel    = ($urandom_range(9) < 7) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    w.start_tick = pva_pkg::TickW'($urandom);
    w.end_tick   = pva_pkg::TickW'($urandom);
    if (roll < 1) begin
      w.operation = pva_pkg::OpClear;
    end else if (roll < 5) begin
      w.operation = ($urandom_range(1) == 0) ? pva_pkg::OpOther : OpSpare;
    end else if (roll < 13) begin
      w.operation = pva_pkg::OpNote;
    end else begin
      w.operation  = pva_pkg::OpNote;
      tick_now     = tick_now + pva_pkg::TickW'($urandom_range(6));
      w.start_tick = tick_now;
      if (roll < 16 && tick_now > 100) begin
        w.end_tick = tick_now - pva_pkg::TickW'($urandom_range(1, 60));
      end else begin
        w.end_tick = tick_now + pva_pkg::TickW'($urandom_range(0, 80));
      end
    end
    return w;
  endfunction

  // send one word after a random gap, predict it once accepted
  task automatic send_word(input pva_pkg::cmd_t w);
    int            gap;
    pva_pkg::res_t pred;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy);
    pred = allocate_voice(w);
    pending_results.push_back(pred);
    words_sent++;
    if (w.operation == pva_pkg::OpClear) clears_sent++;
    if (pred.assigned) notes_placed++;
    if (pred.stolen) steals_seen++;
  endtask

  // hold off until every expected word has come back
  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0 && waited < DrainMax) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  task automatic run_random_words(input int count);
    pva_pkg::cmd_t w;
    int            placed;
    placed   = 0;
    tick_now = ($urandom_range(1) == 0) ? '0 : TickMax - pva_pkg::TickW'(200000);
    while (placed < count) begin
      if ($urandom_range(199) == 0) drain_results();
      w = random_word();
      send_word(w);
      if (w.operation == pva_pkg::OpNote || w.operation == pva_pkg::OpClear) placed++;
    end
    drain_results();
  endtask

  // field extremes, stealing, ties, ignored events, clear
  task automatic test_directed_cases();
    idle_pct = 25;
    send_word(make_word(pva_pkg::OpClear, 0, '0, '0));
    send_word(make_word(pva_pkg::OpNote, 0, '0, TickMax));
    send_word(make_word(pva_pkg::OpNote, 0, '0, TickMax));
    send_word(make_word(pva_pkg::OpNote, 0, '0, 31'd5));
    send_word(make_word(pva_pkg::OpNote, 0, 31'd1, TickMax));
    send_word(make_word(pva_pkg::OpNote, 0, 31'd2, 31'd10));
    send_word(make_word(pva_pkg::OpNote, 0, 31'd5, 31'd20));
    send_word(make_word(pva_pkg::OpOther, 0, 31'd100, TickMax));
    send_word(make_word(OpSpare, 15, TickMax, '0));
    send_word(make_word(pva_pkg::OpNote, 15, TickMax, TickMax));
    send_word(make_word(pva_pkg::OpNote, 15, TickMax, TickMax));
    send_word(make_word(pva_pkg::OpNote, 15, TickMax - 31'd1, TickMax));
    // same start on a full channel
    for (int i = 0; i < 4; i++) send_word(make_word(pva_pkg::OpNote, 9, 31'd7, 31'd100));
    send_word(make_word(pva_pkg::OpNote, 9, 31'd8, 31'd100));
    send_word(make_word(pva_pkg::OpNote, 9, 31'd9, 31'd100));
    // end tick before start tick
    send_word(make_word(pva_pkg::OpNote, 5, 31'd100, 31'd50));
    send_word(make_word(pva_pkg::OpNote, 5, 31'd10, 31'd20));
    send_word(make_word(pva_pkg::OpNote, 5, 31'd60, 31'd70));
    send_word(make_word(pva_pkg::OpClear, 15, TickMax, TickMax));
    send_word(make_word(pva_pkg::OpNote, 0, 31'd3, 31'd4));
    drain_results();
  endtask

  task automatic test_sparse_sender();
    idle_pct = 25;
    run_random_words(550);
  endtask

  task automatic test_slow_sender();
    idle_pct = 84;
    run_random_words(550);
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    run_random_words(550);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        bad_results++;
        if (bad_results <= ShowMax) $display("unexpected result word %h", res_o);
      end else begin
        want = pending_results.pop_front();
        if (res_o.assigned !== want.assigned || res_o.voice_slot !== want.voice_slot ||
            res_o.stolen !== want.stolen || res_o.peak_voices !== want.peak_voices) begin
          bad_results++;
          if (bad_results <= ShowMax)
            $display({"mismatch: expected assigned %b slot %0d stolen %b peak %0d,",
                      " got %b %0d %b %0d"},
                     want.assigned, want.voice_slot, want.stolen, want.peak_voices,
                     res_o.assigned, res_o.voice_slot, res_o.stolen, res_o.peak_voices);
        end
      end
    end
  end

  // sequence
  initial begin
    start        = 1'b0;
    cmd_i        = '0;
    rst_ni       = 1'b0;
    idle_pct     = 0;
    tick_now     = '0;
    words_sent   = 0;
    notes_placed = 0;
    steals_seen  = 0;
    clears_sent  = 0;
    results_seen = 0;
    bad_results  = 0;
    for (int c = 0; c < pva_pkg::Channels; c++) begin
      chan_peak[c] = '0;
      for (int v = 0; v < pva_pkg::Voices; v++) begin
        slot_live[c][v] = 1'b0;
        slot_on[c][v]   = '0;
        slot_off[c][v]  = '0;
      end
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_sparse_sender();
    test_slow_sender();
    test_back_to_back();

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("sent %0d words: %0d notes placed, %0d voices taken over, %0d clears",
             words_sent, notes_placed, steals_seen, clears_sent);
    $display("checked %0d result words, %0d still outstanding",
             results_seen, pending_results.size());
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/pva_pkg.sv
src/pva_ctrl.sv
src/pva_dp.sv
src/polyphonic_voice_allocator.sv
test/tb_polyphonic_voice_allocator.sv
